[hdl/bba_pkg.sv]
package bba_pkg;

  localparam int POOL_LOG2    = 22;
  localparam int MIN_LOG2     = 5;
  localparam int HEADER_BYTES = 24;

  localparam int NCLASS = POOL_LOG2 - MIN_LOG2 + 1;
  localparam int GW     = POOL_LOG2 - MIN_LOG2;
  localparam int NGRAN  = 1 << GW;
  localparam int OW     = 23;
  localparam int KW     = 5;
  localparam int CW     = 5;
  localparam int CNTW   = 18;
  localparam int INFO_W = 7;

  localparam logic [CNTW-1:0] COUNT_MAX  = '1;
  localparam logic [OW-1:0]   POOL_RESET = 23'd2097152;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_REPORT  = 2'd2;
  localparam logic [1:0] CMD_REBUILD = 2'd3;

  typedef struct packed {
    logic [1:0]    cmd;
    logic [OW-1:0] req_bytes;
    logic [OW-1:0] ptr_offset;
  } bba_req_t;

  typedef struct packed {
    logic            ok;
    logic [OW-1:0]   payload_offset;
    logic [CNTW-1:0] pending_count;
  } bba_res_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } bba_stat_t;

endpackage

[hdl/bba_core.sv]
module bba_core import bba_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  bba_req_t      req,
  input  logic [OW-1:0] pool,
  input  logic          res_take,
  output bba_stat_t     stat,
  output bba_res_t      res
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLR    = 5'd1;
  localparam logic [4:0] S_CV_K   = 5'd2;
  localparam logic [4:0] S_CV_ADV = 5'd3;
  localparam logic [4:0] S_AK     = 5'd4;
  localparam logic [4:0] S_AS     = 5'd5;
  localparam logic [4:0] S_SPLIT  = 5'd6;
  localparam logic [4:0] S_F0     = 5'd7;
  localparam logic [4:0] S_F1     = 5'd8;
  localparam logic [4:0] S_M0     = 5'd9;
  localparam logic [4:0] S_M1     = 5'd10;
  localparam logic [4:0] S_M2     = 5'd11;
  localparam logic [4:0] S_FIN    = 5'd12;
  localparam logic [4:0] S_FDONE  = 5'd13;
  localparam logic [4:0] S_P0     = 5'd14;
  localparam logic [4:0] S_P1     = 5'd15;
  localparam logic [4:0] S_P2     = 5'd16;
  localparam logic [4:0] S_R0     = 5'd17;
  localparam logic [4:0] S_R1     = 5'd18;
  localparam logic [4:0] S_DONE   = 5'd19;

  localparam logic [OW-1:0] MIN_BLK  = OW'(1 << MIN_LOG2);
  localparam logic [OW-1:0] POOL_MAX = OW'(1 << POOL_LOG2);

  // memories
  logic [GW-1:0]     nx_mem   [NGRAN];
  logic [GW-1:0]     pv_mem   [NGRAN];
  logic [INFO_W-1:0] info_mem [NGRAN];
  logic [GW-1:0]     nx_rd_r, pv_rd_r;
  logic [INFO_W-1:0] info_rd_r;
  logic              nx_we, pv_we, info_we;
  logic [GW-1:0]     nx_wa, pv_wa, info_wa, nx_ra, pv_ra, info_ra;
  logic [GW-1:0]     nx_wd, pv_wd;
  logic [INFO_W-1:0] info_wd;

  logic [4:0]        state_r, state_nxt, ret_r, ret_nxt;
  logic [GW-1:0]     heads_r [NCLASS];
  logic              head_we;
  logic [GW-1:0]     head_wd;
  logic [NCLASS-1:0] hvalid_r, hvalid_nxt;
  logic [CW-1:0]     sc_r, sc_nxt, c_r, c_nxt;
  logic [GW-1:0]     sg_r, sg_nxt, t_r, t_nxt, g_r, g_nxt, clr_r, clr_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [OW:0]       need_r, need_nxt;
  logic [OW-1:0]     rem_r, rem_nxt, off_r, off_nxt, boff_r, boff_nxt;
  logic [OW-1:0]     extent_r, extent_nxt, boff_c, offw;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic              quiet_r, quiet_nxt;
  bba_res_t          res_r, res_nxt;
  logic [OW:0]       pw;
  logic [GW-1:0]     off_g, boff_g, boffr_g, head_sc;
  logic [CW-1:0]     k_cls, cd;

  always_ff @(posedge clk) begin
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    if (info_we) info_mem[info_wa] <= info_wd;
    nx_rd_r   <= nx_mem[nx_ra];
    pv_rd_r   <= pv_mem[pv_ra];
    info_rd_r <= info_mem[info_ra];
    if (head_we) heads_r[sc_r] <= head_wd;
  end

  assign pw      = (OW+1)'(1) << k_r;
  assign off_g   = off_r[MIN_LOG2+GW-1:MIN_LOG2];
  assign boff_c  = off_r ^ pw[OW-1:0];
  assign boff_g  = boff_c[MIN_LOG2+GW-1:MIN_LOG2];
  assign boffr_g = boff_r[MIN_LOG2+GW-1:MIN_LOG2];
  assign head_sc = heads_r[sc_r];
  assign k_cls   = CW'(k_r - KW'(MIN_LOG2));
  assign cd      = c_r - CW'(1);
  assign offw    = req.ptr_offset - OW'(HEADER_BYTES);

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    hvalid_nxt = hvalid_r;
    sc_nxt     = sc_r;
    sg_nxt     = sg_r;
    t_nxt      = t_r;
    c_nxt      = c_r;
    g_nxt      = g_r;
    clr_nxt    = clr_r;
    k_nxt      = k_r;
    need_nxt   = need_r;
    rem_nxt    = rem_r;
    off_nxt    = off_r;
    boff_nxt   = boff_r;
    extent_nxt = extent_r;
    cnt_nxt    = cnt_r;
    quiet_nxt  = quiet_r;
    res_nxt    = res_r;
    head_we    = 1'b0;
    head_wd    = sg_r;
    nx_we      = 1'b0;
    pv_we      = 1'b0;
    info_we    = 1'b0;
    nx_wa      = sg_r;
    pv_wa      = sg_r;
    nx_wd      = sg_r;
    pv_wd      = sg_r;
    info_wa    = off_g;
    info_wd    = '0;
    nx_ra      = sg_r;
    pv_ra      = sg_r;
    info_ra    = off_g;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          res_nxt = '0;
          unique case (req.cmd)
            CMD_ALLOC: begin
              need_nxt = {1'b0, req.req_bytes} + (OW+1)'(HEADER_BYTES);
              k_nxt    = KW'(MIN_LOG2);
              state_nxt = (req.req_bytes == '0) ? S_DONE : S_AK;
            end
            CMD_FREE: begin
              off_nxt = offw;
              if (req.ptr_offset < OW'(HEADER_BYTES) || offw[MIN_LOG2-1:0] != '0 ||
                  offw >= extent_r) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_F0;
              end
            end
            CMD_REPORT: begin
              res_nxt.pending_count = cnt_r;
              cnt_nxt   = '0;
              state_nxt = S_DONE;
            end
            default: begin
              hvalid_nxt = '0;
              clr_nxt    = '0;
              state_nxt  = S_CLR;
            end
          endcase
        end
      end
      S_CLR: begin
        info_we = 1'b1;
        info_wa = clr_r;
        info_wd = '0;
        clr_nxt = clr_r + GW'(1);
        if (clr_r == '1) begin
          rem_nxt   = (pool > POOL_MAX) ? POOL_MAX : pool;
          off_nxt   = '0;
          k_nxt     = KW'(POOL_LOG2);
          state_nxt = S_CV_K;
        end
      end
      S_CV_K: begin
        if (rem_r < MIN_BLK) begin
          extent_nxt = off_r;
          quiet_nxt  = 1'b0;
          state_nxt  = quiet_r ? S_IDLE : S_DONE;
        end else if ({1'b0, rem_r} < pw) begin
          k_nxt = k_r - KW'(1);
        end else begin
          info_we   = 1'b1;
          info_wd   = {2'b10, k_r};
          sc_nxt    = k_cls;
          sg_nxt    = off_g;
          ret_nxt   = S_CV_ADV;
          state_nxt = S_P0;
        end
      end
      S_CV_ADV: begin
        off_nxt   = off_r + pw[OW-1:0];
        rem_nxt   = rem_r - pw[OW-1:0];
        state_nxt = S_CV_K;
      end
      S_AK: begin
        if (k_r > KW'(POOL_LOG2)) begin
          state_nxt = S_DONE;
        end else if (pw < need_r) begin
          k_nxt = k_r + KW'(1);
        end else begin
          c_nxt     = k_cls;
          state_nxt = S_AS;
        end
      end
      S_AS: begin
        if (c_r >= CW'(NCLASS)) begin
          state_nxt = S_DONE;
        end else if (hvalid_r[c_r]) begin
          g_nxt     = heads_r[c_r];
          sc_nxt    = c_r;
          sg_nxt    = heads_r[c_r];
          ret_nxt   = S_SPLIT;
          state_nxt = S_R0;
        end else begin
          c_nxt = c_r + CW'(1);
        end
      end
      S_SPLIT: begin
        // upper half of each split goes back on its free list
        if ((KW+1)'(c_r) + (KW+1)'(MIN_LOG2) > (KW+1)'(k_r)) begin
          info_we   = 1'b1;
          info_wa   = g_r + (GW'(1) << cd);
          info_wd   = {2'b10, KW'(cd + CW'(MIN_LOG2))};
          c_nxt     = cd;
          sc_nxt    = cd;
          sg_nxt    = g_r + (GW'(1) << cd);
          ret_nxt   = S_SPLIT;
          state_nxt = S_P0;
        end else begin
          info_we = 1'b1;
          info_wa = g_r;
          info_wd = {2'b11, k_r};
          if (cnt_r != COUNT_MAX) cnt_nxt = cnt_r + CNTW'(1);
          res_nxt.ok             = 1'b1;
          res_nxt.payload_offset = OW'({g_r, {MIN_LOG2{1'b0}}}) + OW'(HEADER_BYTES);
          state_nxt = S_DONE;
        end
      end
      S_F0: begin
        state_nxt = S_F1;
      end
      S_F1: begin
        if (info_rd_r[6:5] != 2'b11 || info_rd_r[4:0] < KW'(MIN_LOG2) ||
            info_rd_r[4:0] > KW'(POOL_LOG2)) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt     = info_rd_r[4:0];
          state_nxt = S_M0;
        end
      end
      S_M0: begin
        info_ra = boff_g;
        if (pw < {1'b0, extent_r} && k_r < KW'(POOL_LOG2)) begin
          boff_nxt  = boff_c;
          state_nxt = (boff_c >= extent_r) ? S_FIN : S_M1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_M1: begin
        if (info_rd_r != {2'b10, k_r}) begin
          state_nxt = S_FIN;
        end else begin
          sc_nxt    = k_cls;
          sg_nxt    = boffr_g;
          ret_nxt   = S_M2;
          state_nxt = S_R0;
        end
      end
      S_M2: begin
        info_we = 1'b1;
        if (boff_r < off_r) begin
          info_wa = off_g;
          off_nxt = boff_r;
        end else begin
          info_wa = boffr_g;
        end
        k_nxt     = k_r + KW'(1);
        state_nxt = S_M0;
      end
      S_FIN: begin
        info_we   = 1'b1;
        info_wd   = {2'b10, k_r};
        sc_nxt    = k_cls;
        sg_nxt    = off_g;
        ret_nxt   = S_FDONE;
        state_nxt = S_P0;
      end
      S_FDONE: begin
        if (cnt_r != '0) cnt_nxt = cnt_r - CNTW'(1);
        res_nxt.ok = 1'b1;
        state_nxt  = S_DONE;
      end
      S_P0: begin
        pv_ra = head_sc;
        if (!hvalid_r[sc_r]) begin
          nx_we   = 1'b1;
          pv_we   = 1'b1;
          head_we = 1'b1;
          hvalid_nxt[sc_r] = 1'b1;
          state_nxt = ret_r;
        end else begin
          state_nxt = S_P1;
        end
      end
      S_P1: begin
        nx_we     = 1'b1;
        pv_we     = 1'b1;
        nx_wd     = head_sc;
        pv_wd     = pv_rd_r;
        t_nxt     = pv_rd_r;
        state_nxt = S_P2;
      end
      S_P2: begin
        nx_we     = 1'b1;
        pv_we     = 1'b1;
        nx_wa     = t_r;
        pv_wa     = head_sc;
        head_we   = 1'b1;
        state_nxt = ret_r;
      end
      S_R0: begin
        state_nxt = S_R1;
      end
      S_R1: begin
        if (nx_rd_r == sg_r) begin
          hvalid_nxt[sc_r] = 1'b0;
        end else begin
          nx_we = 1'b1;
          pv_we = 1'b1;
          nx_wa = pv_rd_r;
          nx_wd = nx_rd_r;
          pv_wa = nx_rd_r;
          pv_wd = pv_rd_r;
          if (head_sc == sg_r) begin
            head_we = 1'b1;
            head_wd = nx_rd_r;
          end
        end
        state_nxt = ret_r;
      end
      S_DONE: begin
        if (res_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      hvalid_r <= '0;
      clr_r    <= '0;
      cnt_r    <= '0;
      quiet_r  <= 1'b1;
    end else begin
      state_r  <= state_nxt;
      hvalid_r <= hvalid_nxt;
      clr_r    <= clr_nxt;
      cnt_r    <= cnt_nxt;
      quiet_r  <= quiet_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r    <= ret_nxt;
    sc_r     <= sc_nxt;
    sg_r     <= sg_nxt;
    t_r      <= t_nxt;
    c_r      <= c_nxt;
    g_r      <= g_nxt;
    k_r      <= k_nxt;
    need_r   <= need_nxt;
    rem_r    <= rem_nxt;
    off_r    <= off_nxt;
    boff_r   <= boff_nxt;
    extent_r <= extent_nxt;
    res_r    <= res_nxt;
  end

  assign stat.idle      = (state_r == S_IDLE);
  assign stat.res_valid = (state_r == S_DONE);
  assign res            = res_r;

endmodule

[hdl/buddy_block_allocator.sv]
// buddy allocator over a pool of up to 4 MiB in 32-byte granules
//
// in_valid/in_stall carry one request (cmd, req_bytes, ptr_offset); the block
// stalls its input while a request is in work. out_valid/out_stall carry one
// result per request (ok, payload_offset, pending_count) from an output
// register, so a finished result can wait while the next request runs.
// cfg_we/cfg_wdata set the pool size used by the next rebuild request.
//
// steps per request: report reads and clears the count; allocate runs the size
//   and class search, the unlink, one free list push per split and the finish;
//   free checks the block info, then per merge level reads the buddy and unlinks
//   it, then pushes the merged block; rebuild clears all block info, then carves
//   the pool into blocks of descending size
// a link update to a non-empty list is a read, the registered read data and a write
//
// reset: the count clears and a rebuild from 2 MiB runs, a clearing pass over
// all 131072 block info entries then the carve; no request is taken until it
// is finished and no result is sent for it
// a stalled receiver holds the output register; the core then waits in its
// done state and the input stays stalled
module buddy_block_allocator import bba_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bba_req_t      in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bba_res_t      out_data,
  input  logic          cfg_we,
  input  logic [OW-1:0] cfg_wdata
);

  logic [OW-1:0] pool_r;
  logic          out_valid_r;
  bba_res_t      out_data_r;
  bba_stat_t     stat;
  bba_res_t      core_res;
  logic          start, res_take;

  // only an idle core takes a request
  assign in_stall = !stat.idle;
  assign start    = in_valid && stat.idle;

  // output register is free or drains this cycle
  assign res_take = stat.res_valid && (!out_valid_r || !out_stall);

  bba_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req      (in_data),
    .pool     (pool_r),
    .res_take (res_take),
    .stat     (stat),
    .res      (core_res)
  );

  // pool size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= POOL_RESET;
    end else if (cfg_we) begin
      pool_r <= cfg_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_data_r <= core_res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[verif/tb_buddy_block_allocator.sv]
`timescale 1ns / 100ps

module tb_buddy_block_allocator;
  import bba_pkg::*;

  // clock, reset and block ports
  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  bba_req_t      in_data;
  logic          out_valid;
  logic          out_stall;
  bba_res_t      out_data;
  logic          cfg_we;
  logic [OW-1:0] cfg_wdata;

  buddy_block_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // allocator image kept by the testbench, mirrors the block's own memories
  localparam longint unsigned HEAP_MAX = 64'd1 << POOL_LOG2;
  localparam int unsigned     GMASK    = NGRAN - 1;
  localparam int unsigned     CNT_SAT  = 262143;
  localparam logic [6:0]      BLK_START = 7'h40;
  localparam logic [6:0]      BLK_FULL  = 7'h20;

  bit              class_valid [NCLASS];
  int unsigned     class_head [NCLASS];
  int unsigned     gran_next [NGRAN];
  int unsigned     gran_prev [NGRAN];
  logic [6:0]      gran_info [NGRAN];
  int unsigned     live_count;
  longint unsigned carved_bytes;
  logic [OW-1:0]   pool_reg;

  // results still owed by the block, oldest first
  bba_res_t        owed_results[$];
  // payload offsets currently handed out, used to pick frees
  int unsigned     live_ptrs[$];

  int              mismatches;
  int              hold_cycles;
  int              stall_pct;

  // free list helpers
  function automatic void class_push(int unsigned c, int unsigned g);
    int unsigned h, t;
    g &= GMASK;
    if (!class_valid[c]) begin
      gran_next[g] = g;
      gran_prev[g] = g;
    end else begin
      h = class_head[c];
      t = gran_prev[h] & GMASK;
      gran_next[g] = h;
      gran_prev[g] = t;
      gran_next[t] = g;
      gran_prev[h] = g;
    end
    class_valid[c] = 1'b1;
    class_head[c]  = g;
  endfunction

  function automatic void class_unlink(int unsigned c, int unsigned g);
    int unsigned n, p;
    g &= GMASK;
    n = gran_next[g] & GMASK;
    p = gran_prev[g] & GMASK;
    if (n == g) begin
      class_valid[c] = 1'b0;
      class_head[c]  = 0;
    end else begin
      gran_next[p] = n;
      gran_prev[n] = p;
      if (class_head[c] == g) class_head[c] = n;
    end
  endfunction

  // carve the pool from offset 0 into descending power-of-two blocks
  function automatic void carve_pool();
    longint unsigned rem, off;
    int unsigned k, g;
    rem = pool_reg;
    off = 0;
    for (int i = 0; i < NCLASS; i++) begin
      class_valid[i] = 1'b0;
      class_head[i]  = 0;
    end
    for (int i = 0; i < NGRAN; i++) gran_info[i] = '0;
    if (rem > HEAP_MAX) rem = HEAP_MAX;
    while (rem >= (64'd1 << MIN_LOG2)) begin
      k = POOL_LOG2;
      while ((64'd1 << k) > rem) k--;
      g = (off >> MIN_LOG2) & GMASK;
      gran_info[g] = BLK_START | 7'(k);
      class_push(k - MIN_LOG2, g);
      off += 64'd1 << k;
      rem -= 64'd1 << k;
    end
    carved_bytes = off;
  endfunction

  function automatic bit take_block(longint unsigned req, output longint unsigned payload);
    longint unsigned need;
    int unsigned k, c, g, hg;
    need    = req + HEADER_BYTES;
    k       = MIN_LOG2;
    payload = 0;
    if (req == 0) return 1'b0;
    while (k <= POOL_LOG2 && (64'd1 << k) < need) k++;
    if (k > POOL_LOG2) return 1'b0;
    c = k - MIN_LOG2;
    while (c < NCLASS && !class_valid[c]) c++;
    if (c >= NCLASS) return 1'b0;
    g = class_head[c];
    class_unlink(c, g);
    // upper halves go back on the free lists
    while (c + MIN_LOG2 > k) begin
      c--;
      hg = (g + (1 << c)) & GMASK;
      gran_info[hg] = BLK_START | 7'(c + MIN_LOG2);
      class_push(c, hg);
    end
    gran_info[g] = BLK_START | BLK_FULL | 7'(k);
    if (live_count < CNT_SAT) live_count++;
    payload = (longint'(g) << MIN_LOG2) + HEADER_BYTES;
    return 1'b1;
  endfunction

  function automatic bit give_back(longint unsigned ptr);
    longint unsigned off, boff;
    int unsigned g, bg, lg;
    if (ptr < HEADER_BYTES) return 1'b0;
    off = ptr - HEADER_BYTES;
    if ((off & ((64'd1 << MIN_LOG2) - 1)) != 0 || off >= carved_bytes) return 1'b0;
    g = (off >> MIN_LOG2) & GMASK;
    if ((gran_info[g] & (BLK_START | BLK_FULL)) != (BLK_START | BLK_FULL)) return 1'b0;
    lg = gran_info[g] & 7'h1f;
    if (lg < MIN_LOG2 || lg > POOL_LOG2) return 1'b0;
    // merge upward while the buddy is a free block of the same size
    while ((64'd1 << lg) < carved_bytes && lg < POOL_LOG2) begin
      boff = off ^ (64'd1 << lg);
      if (boff >= carved_bytes) break;
      bg = (boff >> MIN_LOG2) & GMASK;
      if (gran_info[bg] != (BLK_START | 7'(lg))) break;
      class_unlink(lg - MIN_LOG2, bg);
      if (boff < off) begin
        gran_info[g] = '0;
        off = boff;
        g   = bg;
      end else begin
        gran_info[bg] = '0;
      end
      lg++;
    end
    gran_info[g] = BLK_START | 7'(lg);
    class_push(lg - MIN_LOG2, g);
    if (live_count > 0) live_count--;
    return 1'b1;
  endfunction

  // expected result of one request, updates the image
  function automatic bba_res_t predict_result(bba_req_t r);
    bba_res_t        res;
    longint unsigned pay;
    res = '0;
    case (r.cmd)
      CMD_ALLOC: begin
        res.ok = take_block(r.req_bytes, pay);
        res.payload_offset = OW'(pay);
      end
      CMD_FREE: res.ok = give_back(r.ptr_offset);
      CMD_REPORT: begin
        res.pending_count = CNTW'(live_count);
        live_count = 0;
      end
      default: carve_pool();
    endcase
    return res;
  endfunction

  // drive one request and wait until the block takes it
  task automatic send_request(logic [1:0] cmd, int unsigned req, int unsigned ptr);
    bba_req_t r;
    bba_res_t res;
    r.cmd        = cmd;
    r.req_bytes  = OW'(req);
    r.ptr_offset = OW'(ptr);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    res = predict_result(r);
    owed_results.push_back(res);
    if (cmd == CMD_ALLOC && res.ok) live_ptrs.push_back(res.payload_offset);
    if (cmd == CMD_REBUILD) live_ptrs.delete();
  endtask

  task automatic idle_sender(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    idle_sender(1);
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_pool(int unsigned v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= OW'(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
    pool_reg  = OW'(v);
  endtask

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    bba_res_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        exp_res = owed_results.pop_front();
        if (out_data.ok !== exp_res.ok
            || out_data.payload_offset !== exp_res.payload_offset
            || out_data.pending_count !== exp_res.pending_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected ok=%0d off=%0d cnt=%0d, got ok=%0d off=%0d cnt=%0d",
                     exp_res.ok, exp_res.payload_offset, exp_res.pending_count,
                     out_data.ok, out_data.payload_offset, out_data.pending_count);
        end
      end
    end
  end

  // receiver stall: forced hold-off first, else a random duty that shifts
  initial begin
    int mode_left;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(20, 150);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        mode_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // edge cases on the reset pool of 2 MiB
  task automatic test_directed();
    send_request(CMD_ALLOC, 0, 0);             // zero request
    send_request(CMD_ALLOC, 1, 0);             // smallest block
    send_request(CMD_FREE, 0, 24);             // merges all the way back
    send_request(CMD_ALLOC, 2097128, 8388607); // whole heap
    send_request(CMD_ALLOC, 1, 0);             // nothing left
    send_request(CMD_FREE, 0, 24);
    send_request(CMD_FREE, 0, 24);             // double free
    send_request(CMD_ALLOC, 4194280, 0);       // fits the class limit, not the heap
    send_request(CMD_ALLOC, 8388607, 0);       // too large
    send_request(CMD_FREE, 0, 0);              // below the header
    send_request(CMD_FREE, 0, 25);             // not granule aligned
    send_request(CMD_FREE, 0, 2097152 + 24);   // beyond the extent
    send_request(CMD_FREE, 8388607, 8388607);
    send_request(CMD_ALLOC, 8, 0);             // exactly one granule
    send_request(CMD_ALLOC, 9, 0);             // rounds up to 64
    send_request(CMD_FREE, 0, 88);             // free block start
    send_request(CMD_FREE, 0, 120);            // inside a block
    send_request(CMD_REPORT, 0, 0);
    send_request(CMD_FREE, 0, 24);
    send_request(CMD_FREE, 0, 88);
    send_request(CMD_REPORT, 0, 0);
    wait_drained();
  endtask

  // receiver holds off long enough that the block backs up its input
  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 12; i++) send_request(CMD_ALLOC, $urandom_range(1, 300), 0);
    wait_drained();
    send_request(CMD_REPORT, 0, 0);
    wait_drained();
  endtask

  // pool register extremes, each followed by a rebuild
  task automatic test_pool_sizes();
    write_pool(8388607);                       // clamps to 4 MiB
    send_request(CMD_REBUILD, 0, 0);
    send_request(CMD_ALLOC, 4194280, 0);
    send_request(CMD_ALLOC, 1, 0);
    send_request(CMD_FREE, 0, 24);
    send_request(CMD_ALLOC, 4194281, 0);
    wait_drained();
    write_pool(31);                            // empty heap
    send_request(CMD_REBUILD, 0, 0);
    send_request(CMD_ALLOC, 1, 0);
    send_request(CMD_FREE, 0, 24);
    wait_drained();
    write_pool(32);                            // one granule
    send_request(CMD_REBUILD, 0, 0);
    send_request(CMD_ALLOC, 8, 0);
    send_request(CMD_ALLOC, 8, 0);
    send_request(CMD_FREE, 0, 24);
    send_request(CMD_REPORT, 0, 0);
    wait_drained();
  endtask

  // random traffic on a small odd-sized pool, in bursts with gaps
  task automatic test_random_traffic(int n);
    int          burst_left, pick, idx;
    int unsigned ptr;
    write_pool(16384 + $urandom_range(0, 16383));
    send_request(CMD_REBUILD, 0, 0);
    burst_left = 0;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
      end
      burst_left--;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_request(CMD_ALLOC, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3000)
                                                            : $urandom_range(1, 200),
                     $urandom);
      end else if (pick < 80 && live_ptrs.size() != 0) begin
        idx = $urandom_range(0, live_ptrs.size() - 1);
        ptr = live_ptrs[idx];
        live_ptrs.delete(idx);
        send_request(CMD_FREE, $urandom, ptr);
      end else if (pick < 88) begin
        // broken pointers: random, shifted or into a granule
        case ($urandom_range(0, 2))
          0: ptr = $urandom;
          1: ptr = $urandom_range(0, 40000);
          default: ptr = 24 + 32 * $urandom_range(0, 1000);
        endcase
        send_request(CMD_FREE, $urandom, ptr);
      end else if (pick < 94) begin
        send_request(CMD_REPORT, $urandom, $urandom);
      end else begin
        // wide or zero requests
        send_request(CMD_ALLOC, ($urandom_range(0, 1) == 0) ? 0 : $urandom, $urandom);
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    mismatches  = 0;
    hold_cycles = 0;
    stall_pct   = 0;
    live_count  = 0;
    pool_reg    = POOL_RESET;
    for (int i = 0; i < NGRAN; i++) begin
      gran_next[i] = 0;
      gran_prev[i] = 0;
    end
    carve_pool();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_pool_sizes();
    test_random_traffic(1700);

    repeat (300) @(posedge clk);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("buddy_block_allocator regression: pass");
    end else begin
      $display("buddy_block_allocator regression: fail");
    end
    $finish;
  end

  // guard against a hung block: reset clear plus four rebuilds dominate
  initial begin
    #50_000_000;
    $display("buddy_block_allocator regression: fail");
    $finish;
  end

endmodule
